[rtl/rrq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared constants, codes and control/status structs for the round-robin
// ready queues.
// ----------------------------------------------------------------------------
package rrq_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int RECORD_POOL = 1024;

  // payload field widths
  localparam int REC_W = 10;
  localparam int WK_W  = 4;
  localparam int WC_W  = 5;
  localparam int ST_W  = 2;

  // derived storage widths
  localparam int A_W   = (RECORD_POOL > 1) ? $clog2(RECORD_POOL) : 1;
  localparam int Q_W   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W = $clog2(MAX_WORKERS + 1);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_BIND_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LEVEL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 2'd2;

  // commands
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [ST_W-1:0] ST_IGNORED = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic set_ignored;
    logic link_step;
    logic append;
    logic deal_step;
    logic dq_check;
    logic dq_wb;
    logic emit;
  } rrq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_dequeue;
    logic range_bad;
    logic bind_mode;
    logic at_last;
    logic dq_empty;
    logic dq_last;
    logic out_free;
  } rrq_sts_t;

endpackage

[rtl/rrq_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_in_if
// Command channel: enqueue a record range or dequeue for a worker.
// ----------------------------------------------------------------------------
interface rrq_in_if;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [rrq_pkg::REC_W-1:0] first_record;
  logic [rrq_pkg::REC_W-1:0] last_record;
  logic [rrq_pkg::WK_W-1:0]  worker;

  modport source (output valid, cmd, first_record, last_record, worker, input ready);
  modport sink   (input valid, cmd, first_record, last_record, worker, output ready);
endinterface

[rtl/rrq_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_out_if
// Result channel: dequeued record and status.
// ----------------------------------------------------------------------------
interface rrq_out_if;
  logic                     valid;
  logic                     ready;
  logic [rrq_pkg::REC_W-1:0] record;
  logic [rrq_pkg::ST_W-1:0]  status;

  modport source (output valid, record, status, input ready);
  modport sink   (input valid, record, status, output ready);
endinterface

[rtl/rrq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_ctrl
// Sequencer: takes one command at a time and steps the datapath through the
// range walk, the tail append or the dequeue read.
// ----------------------------------------------------------------------------
module rrq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rrq_pkg::rrq_sts_t sts_i,
  output rrq_pkg::rrq_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DISP   = 8'b0000_0010,
    S_LINK   = 8'b0000_0100,
    S_APPEND = 8'b0000_1000,
    S_DEAL   = 8'b0001_0000,
    S_DQ_CHK = 8'b0010_0000,
    S_DQ_WB  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } rrq_state_t;

  rrq_state_t state_r;
  rrq_state_t state_nxt;
  logic       in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_o.load_item = 1'b1;
          state_nxt       = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.is_dequeue) begin
          state_nxt = S_DQ_CHK;
        end else if (sts_i.range_bad) begin
          cmd_o.set_ignored = 1'b1;
          state_nxt         = S_DONE;
        end else if (sts_i.bind_mode) begin
          state_nxt = S_DEAL;
        end else begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        // chain cur -> cur+1 until the last record of the range
        cmd_o.link_step = 1'b1;
        if (sts_i.at_last) begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd_o.append = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DEAL: begin
        cmd_o.deal_step = 1'b1;
        if (sts_i.at_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DQ_CHK: begin
        cmd_o.dq_check = 1'b1;
        if (sts_i.dq_empty || sts_i.dq_last) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DQ_WB;
        end
      end
      S_DQ_WB: begin
        cmd_o.dq_wb = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_disp: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_DISP))
    else $error("accepted command did not go to dispatch");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && !sts_i.out_free |=> (state_r == S_DONE))
    else $error("result left while output register was full");
`endif

endmodule

[rtl/rrq_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_dp
// Datapath: configuration registers, per-queue head/tail/nonempty, the
// next-link memory, the walk counters and the result output register.
// ----------------------------------------------------------------------------
module rrq_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rrq_pkg::rrq_cmd_t                cmd_i,
  output rrq_pkg::rrq_sts_t                sts_o,
  input  logic                             cfg_we,
  input  logic [rrq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrq_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_cmd,
  input  logic [rrq_pkg::REC_W-1:0]        in_first,
  input  logic [rrq_pkg::REC_W-1:0]        in_last,
  input  logic [rrq_pkg::WK_W-1:0]         in_worker,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rrq_pkg::REC_W-1:0]        out_record,
  output logic [rrq_pkg::ST_W-1:0]         out_status
);

  // configuration
  logic                        bind_mode_r;
  logic                        one_level_r;
  logic [rrq_pkg::WC_W-1:0]    worker_count_r;

  // latched command
  logic                        cmd_r;
  logic [rrq_pkg::REC_W-1:0]   first_r;
  logic [rrq_pkg::REC_W-1:0]   last_r;
  logic [rrq_pkg::WK_W-1:0]    worker_r;

  // walk counters
  logic [rrq_pkg::REC_W-1:0]   cur_r;
  logic [rrq_pkg::Q_W-1:0]     pid_r;
  logic [rrq_pkg::Q_W:0]       pid_inc;
  logic [rrq_pkg::CNT_W-1:0]   active_n;

  // queue state
  logic [rrq_pkg::REC_W-1:0]   head_r     [rrq_pkg::MAX_WORKERS];
  logic [rrq_pkg::REC_W-1:0]   tail_r     [rrq_pkg::MAX_WORKERS];
  logic [rrq_pkg::MAX_WORKERS-1:0] nonempty_r;

  // link memory
  logic [rrq_pkg::REC_W-1:0]   link_mem   [rrq_pkg::RECORD_POOL];
  logic [rrq_pkg::REC_W-1:0]   link_rdata_r;
  logic                        rd_ok_r;
  logic                        mem_we;
  logic [rrq_pkg::REC_W-1:0]   mem_waddr;
  logic [rrq_pkg::REC_W-1:0]   mem_wdata;

  // result and output registers
  logic [rrq_pkg::REC_W-1:0]   res_rec_r;
  logic [rrq_pkg::ST_W-1:0]    res_status_r;
  logic                        out_valid_r;
  logic [rrq_pkg::REC_W-1:0]   out_record_r;
  logic [rrq_pkg::ST_W-1:0]    out_status_r;

  logic [rrq_pkg::Q_W-1:0]     qsel;
  logic                        q_oob;
  logic [rrq_pkg::REC_W-1:0]   sel_head;
  logic [rrq_pkg::REC_W-1:0]   sel_tail;
  logic                        sel_nonempty;
  logic                        at_last;
  logic                        out_free;

  // worker count 0 acts as 1, above the queue count it saturates
  always_comb begin
    if (worker_count_r == '0) begin
      active_n = rrq_pkg::CNT_W'(1);
    end else if (32'(worker_count_r) > rrq_pkg::MAX_WORKERS) begin
      active_n = rrq_pkg::CNT_W'(rrq_pkg::MAX_WORKERS);
    end else begin
      active_n = rrq_pkg::CNT_W'(worker_count_r);
    end
  end

  assign pid_inc = {1'b0, pid_r} + 1'b1;
  assign at_last = (cur_r == last_r);

  // one read port into the head/tail/nonempty file per cycle
  always_comb begin
    if (cmd_i.append) begin
      qsel = '0;
    end else if (cmd_i.deal_step) begin
      qsel = pid_r;
    end else if (bind_mode_r) begin
      qsel = rrq_pkg::Q_W'(worker_r);
    end else begin
      qsel = '0;
    end
  end

  assign q_oob        = bind_mode_r && (32'(worker_r) >= rrq_pkg::MAX_WORKERS);
  assign sel_head     = head_r[qsel];
  assign sel_tail     = tail_r[qsel];
  assign sel_nonempty = nonempty_r[qsel];
  assign out_free     = !out_valid_r || out_ready;

  assign sts_o.is_dequeue = (cmd_r == rrq_pkg::CMD_DEQUEUE);
  assign sts_o.range_bad  = (first_r > last_r) || (32'(last_r) >= rrq_pkg::RECORD_POOL);
  assign sts_o.bind_mode  = bind_mode_r;
  assign sts_o.at_last    = at_last;
  assign sts_o.dq_empty   = q_oob || !sel_nonempty;
  assign sts_o.dq_last    = (sel_head == sel_tail);
  assign sts_o.out_free   = out_free;

  // link memory write source
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_r;
    mem_wdata = cur_r + rrq_pkg::REC_W'(1);
    if (cmd_i.link_step && !at_last) begin
      mem_we = 1'b1;
    end else if (cmd_i.append) begin
      mem_we    = sel_nonempty;
      mem_waddr = sel_tail;
      mem_wdata = first_r;
    end else if (cmd_i.deal_step && !one_level_r) begin
      mem_we    = sel_nonempty;
      mem_waddr = sel_tail;
      mem_wdata = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we && (32'(mem_waddr) < rrq_pkg::RECORD_POOL)) begin
      link_mem[rrq_pkg::A_W'(mem_waddr)] <= mem_wdata;
    end
    if (cmd_i.dq_check) begin
      link_rdata_r <= link_mem[rrq_pkg::A_W'(sel_head)];
      rd_ok_r      <= (32'(sel_head) < rrq_pkg::RECORD_POOL);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bind_mode_r    <= 1'b0;
      one_level_r    <= 1'b0;
      worker_count_r <= rrq_pkg::WC_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        rrq_pkg::CFG_BIND_MODE:    bind_mode_r    <= cfg_data[0];
        rrq_pkg::CFG_ONE_LEVEL:    one_level_r    <= cfg_data[0];
        rrq_pkg::CFG_WORKER_COUNT: worker_count_r <= cfg_data[rrq_pkg::WC_W-1:0];
        default: ;
      endcase
    end
  end

  // command latch, walk counters and result
  always_ff @(posedge clk) begin
    if (cmd_i.load_item) begin
      cmd_r        <= in_cmd;
      first_r      <= in_first;
      last_r       <= in_last;
      worker_r     <= in_worker;
      cur_r        <= in_first;
      pid_r        <= '0;
      res_rec_r    <= '0;
      res_status_r <= rrq_pkg::ST_OK;
    end
    if (cmd_i.set_ignored) begin
      res_status_r <= rrq_pkg::ST_IGNORED;
    end
    if ((cmd_i.link_step || cmd_i.deal_step) && !at_last) begin
      cur_r <= cur_r + rrq_pkg::REC_W'(1);
    end
    if (cmd_i.deal_step && !at_last) begin
      if (32'(pid_inc) >= 32'(active_n)) begin
        pid_r <= '0;
      end else begin
        pid_r <= pid_inc[rrq_pkg::Q_W-1:0];
      end
    end
    if (cmd_i.dq_check) begin
      if (q_oob || !sel_nonempty) begin
        res_status_r <= rrq_pkg::ST_EMPTY;
      end else begin
        res_rec_r <= sel_head;
      end
    end
  end

  // queue head, tail and nonempty flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rrq_pkg::MAX_WORKERS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
      nonempty_r <= '0;
    end else begin
      if (cmd_i.append) begin
        if (!sel_nonempty) begin
          head_r[qsel]     <= first_r;
          nonempty_r[qsel] <= 1'b1;
        end
        tail_r[qsel] <= last_r;
      end
      if (cmd_i.deal_step) begin
        if (one_level_r || !sel_nonempty) begin
          head_r[qsel] <= cur_r;
        end
        tail_r[qsel]     <= cur_r;
        nonempty_r[qsel] <= 1'b1;
      end
      // popping the tail empties the queue; the tail link is never followed
      if (cmd_i.dq_check && !q_oob && sel_nonempty && (sel_head == sel_tail)) begin
        nonempty_r[qsel] <= 1'b0;
      end
      if (cmd_i.dq_wb) begin
        head_r[qsel] <= rd_ok_r ? link_rdata_r : '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      out_record_r <= res_rec_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_record = out_record_r;
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.emit |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken transfer");

  a_no_record_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != rrq_pkg::ST_OK) |-> (out_record_r == '0))
    else $error("record given with a failing status");
`endif

endmodule

[rtl/round_robin_ready_queues.sv]
`timescale 1ns / 1ps
// Sequence: a dequeue is dispatched, checks its queue and, when the head link is
// read from the link memory, writes the new head back; an enqueue walks its range
// record by record (with a tail append outside bind mode), or is ignored at dispatch.
// Flow: one command at a time; the next is taken once the result has
// entered the output register, which may still wait on the sink.
// Reset: synchronous active-low; all queues empty, config back to defaults.
// ----------------------------------------------------------------------------
// round_robin_ready_queues
// Per-worker linked FIFOs of record numbers with round-robin range dealing.
// ----------------------------------------------------------------------------
module round_robin_ready_queues (
  input  logic                           clk,
  input  logic                           rst_n,
  rrq_in_if.sink                         in_ch,
  rrq_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [rrq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrq_pkg::CFG_DATA_W-1:0] cfg_data
);

  rrq_pkg::rrq_cmd_t cmd;
  rrq_pkg::rrq_sts_t sts;

  rrq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  rrq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_cmd     (in_ch.cmd),
    .in_first   (in_ch.first_record),
    .in_last    (in_ch.last_record),
    .in_worker  (in_ch.worker),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_record (out_ch.record),
    .out_status (out_ch.status)
  );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the round-robin ready queues. A directed table of
// commands and register writes runs first, followed by randomized phases over
// several mode settings and idle patterns. Every accepted command goes through
// a behavioral queue predictor, and each result is checked against the oldest
// predicted result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STALL_LIMIT   = 8000;
  localparam int PHASE_ITEMS   = 100;
  localparam int LONG_HOLD     = 300;
  localparam int GAP_PCT       = 78;
  localparam int BOTH_PCT      = 26;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic                      cmd;
    logic [rrq_pkg::REC_W-1:0] first_rec;
    logic [rrq_pkg::REC_W-1:0] last_rec;
    logic [rrq_pkg::WK_W-1:0]  worker;
  } queue_cmd_t;

  typedef struct packed {
    logic [rrq_pkg::REC_W-1:0] record;
    logic [rrq_pkg::ST_W-1:0]  status;
  } queue_res_t;

  typedef struct {
    bit                             is_cfg;
    logic [rrq_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [rrq_pkg::CFG_DATA_W-1:0] reg_val;
    queue_cmd_t                     c;
    bit                             typed;
    queue_res_t                     want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [rrq_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rrq_pkg::CFG_DATA_W-1:0] cfg_data;

  rrq_in_if  in_bus();
  rrq_out_if out_bus();

  round_robin_ready_queues dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // predictor state: per-worker lists plus the shared link memory
  logic [rrq_pkg::REC_W-1:0] q_head [rrq_pkg::MAX_WORKERS];
  logic [rrq_pkg::REC_W-1:0] q_tail [rrq_pkg::MAX_WORKERS];
  bit                        q_live [rrq_pkg::MAX_WORKERS];
  logic [rrq_pkg::REC_W-1:0] link_mem [rrq_pkg::RECORD_POOL];
  bit                        link_set [rrq_pkg::RECORD_POOL];
  bit                        bind_r;
  bit                        one_level_r;
  logic [rrq_pkg::WC_W-1:0]  wcount_r;

  queue_res_t expected_results[$];
  step_row_t  directed_rows[$];
  int         fault_count = 0;
  int         send_gap_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_token = 0;

  function automatic int active_workers();
    if (wcount_r == 0) return 1;
    if (int'(wcount_r) > rrq_pkg::MAX_WORKERS) return rrq_pkg::MAX_WORKERS;
    return int'(wcount_r);
  endfunction

  function automatic void link_into(int q, int first_r, int last_r);
    if (q_live[q]) begin
      link_mem[q_tail[q]] = rrq_pkg::REC_W'(first_r);
      link_set[q_tail[q]] = 1'b1;
    end else begin
      q_head[q] = rrq_pkg::REC_W'(first_r);
      q_live[q] = 1'b1;
    end
    q_tail[q] = rrq_pkg::REC_W'(last_r);
  endfunction

  function automatic queue_res_t run_command(queue_cmd_t c);
    queue_res_t res;
    int n;
    int pid;
    int q;
    res.record = '0;
    res.status = rrq_pkg::ST_OK;
    if (c.cmd == rrq_pkg::CMD_ENQUEUE) begin
      if (c.first_rec > c.last_rec) begin
        res.status = rrq_pkg::ST_IGNORED;
      end else if (bind_r) begin
        n = active_workers();
        pid = 0;
        for (int r = int'(c.first_rec); r <= int'(c.last_rec); r++) begin
          if (one_level_r) begin
            q_head[pid] = rrq_pkg::REC_W'(r);
            q_tail[pid] = rrq_pkg::REC_W'(r);
            q_live[pid] = 1'b1;
          end else begin
            link_into(pid, r, r);
          end
          pid = (pid + 1 >= n) ? 0 : pid + 1;
        end
      end else begin
        for (int r = int'(c.first_rec); r < int'(c.last_rec); r++) begin
          link_mem[r] = rrq_pkg::REC_W'(r + 1);
          link_set[r] = 1'b1;
        end
        link_into(0, int'(c.first_rec), int'(c.last_rec));
      end
    end else begin
      q = bind_r ? int'(c.worker) : 0;
      if (!q_live[q]) begin
        res.status = rrq_pkg::ST_EMPTY;
      end else begin
        res.record = q_head[q];
        if (q_head[q] == q_tail[q]) q_live[q] = 1'b0;
        else q_head[q] = link_mem[q_head[q]];
      end
    end
    return res;
  endfunction

  // a pop must never make the block follow a link that was never written
  function automatic bit dequeue_safe(logic [rrq_pkg::WK_W-1:0] worker);
    int q;
    q = bind_r ? int'(worker) : 0;
    return !(q_live[q] && q_head[q] != q_tail[q] && !link_set[q_head[q]]);
  endfunction

  function automatic queue_cmd_t pick_command();
    queue_cmd_t c;
    int span;
    int lo;
    int roll;
    c.cmd = rrq_pkg::CMD_ENQUEUE;
    c.worker = rrq_pkg::WK_W'($urandom_range(rrq_pkg::MAX_WORKERS - 1));
    c.first_rec = '0;
    c.last_rec = '0;
    roll = int'($urandom_range(99));
    if (roll < 45) begin
      c.cmd = rrq_pkg::CMD_DEQUEUE;
      if (bind_r && $urandom_range(99) < 80)
        c.worker = rrq_pkg::WK_W'($urandom_range(active_workers() - 1));
    end else if (roll < 49) begin
      c.first_rec = rrq_pkg::REC_W'($urandom_range(rrq_pkg::RECORD_POOL - 1, 1));
      c.last_rec = rrq_pkg::REC_W'($urandom_range(int'(c.first_rec) - 1));
    end else begin
      roll = int'($urandom_range(99));
      if (roll < 85) span = int'($urandom_range(8, 1));
      else if (roll < 97) span = int'($urandom_range(64, 9));
      else span = int'($urandom_range(rrq_pkg::RECORD_POOL, 65));
      lo = int'($urandom_range(rrq_pkg::RECORD_POOL - span));
      c.first_rec = rrq_pkg::REC_W'(lo);
      c.last_rec = rrq_pkg::REC_W'(lo + span - 1);
    end
    if (c.cmd == rrq_pkg::CMD_DEQUEUE && !dequeue_safe(c.worker)) begin
      // reversed range instead: ignored, leaves the lists alone
      c.cmd = rrq_pkg::CMD_ENQUEUE;
      c.first_rec = 10'd1;
      c.last_rec = 10'd0;
    end
    return c;
  endfunction

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic step_row_t cmd_row(logic cmd, int first_r, int last_r, int worker);
    step_row_t row;
    row.is_cfg = 1'b0;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.c.cmd = cmd;
    row.c.first_rec = rrq_pkg::REC_W'(first_r);
    row.c.last_rec = rrq_pkg::REC_W'(last_r);
    row.c.worker = rrq_pkg::WK_W'(worker);
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic void add_cmd(logic cmd, int first_r, int last_r, int worker);
    directed_rows.push_back(cmd_row(cmd, first_r, last_r, worker));
  endfunction

  function automatic void add_typed(logic cmd, int first_r, int last_r, int worker,
                                    int rec, logic [rrq_pkg::ST_W-1:0] st);
    step_row_t row;
    row = cmd_row(cmd, first_r, last_r, worker);
    row.typed = 1'b1;
    row.want.record = rrq_pkg::REC_W'(rec);
    row.want.status = st;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [rrq_pkg::CFG_IDX_W-1:0] idx, int val);
    step_row_t row;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = rrq_pkg::CFG_DATA_W'(val);
    row.c = '0;
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endfunction

  // drop valid and wait until every predicted result has been taken
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [rrq_pkg::CFG_IDX_W-1:0] idx, int val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= rrq_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rrq_pkg::CFG_BIND_MODE:    bind_r = val[0];
      rrq_pkg::CFG_ONE_LEVEL:    one_level_r = val[0];
      rrq_pkg::CFG_WORKER_COUNT: wcount_r = rrq_pkg::WC_W'(val);
      default: ;
    endcase
  endtask

  task automatic send_command(queue_cmd_t c, bit typed, queue_res_t want);
    queue_res_t got;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.cmd <= c.cmd;
    in_bus.first_record <= c.first_rec;
    in_bus.last_record <= c.last_rec;
    in_bus.worker <= c.worker;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    got = run_command(c);
    expected_results.push_back(typed ? want : got);
  endtask

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_SEND: begin send_gap_pct = GAP_PCT;  recv_stall_pct = 0;        end
      IDLE_RECV: begin send_gap_pct = 0;        recv_stall_pct = GAP_PCT;  end
      IDLE_BOTH: begin send_gap_pct = BOTH_PCT; recv_stall_pct = BOTH_PCT; end
      default:   begin send_gap_pct = 0;        recv_stall_pct = 0;        end
    endcase
  endtask

  // result side: ready pattern, long hold-off and result checking
  initial begin : result_side
    queue_res_t want;
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        if (expected_results.size() == 0) begin
          note_fault($sformatf("result record=%0d status=%0d with nothing pending",
                               out_bus.record, out_bus.status));
        end else begin
          want = expected_results.pop_front();
          if (out_bus.record !== want.record)
            note_fault($sformatf("record expected %0d got %0d", want.record, out_bus.record));
          if (out_bus.status !== want.status)
            note_fault($sformatf("status expected %0d got %0d", want.status, out_bus.status));
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("round_robin_ready_queues verification failed");
    $finish;
  end

  initial begin : stimulus
    queue_cmd_t c;
    idle_mode_t mode;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.cmd = rrq_pkg::CMD_ENQUEUE;
    in_bus.first_record = '0;
    in_bus.last_record = '0;
    in_bus.worker = '0;
    for (int i = 0; i < rrq_pkg::MAX_WORKERS; i++) begin
      q_head[i] = '0;
      q_tail[i] = '0;
      q_live[i] = 1'b0;
    end
    for (int i = 0; i < rrq_pkg::RECORD_POOL; i++) begin
      link_mem[i] = '0;
      link_set[i] = 1'b0;
    end
    bind_r = 1'b0;
    one_level_r = 1'b0;
    wcount_r = 5'd1;

    // reset defaults: queue zero only
    add_typed(rrq_pkg::CMD_DEQUEUE, 0, 0, 0, 0, rrq_pkg::ST_EMPTY);
    add_typed(rrq_pkg::CMD_ENQUEUE, 5, 3, 0, 0, rrq_pkg::ST_IGNORED);
    add_typed(rrq_pkg::CMD_ENQUEUE, 1023, 1023, 15, 0, rrq_pkg::ST_OK);
    add_typed(rrq_pkg::CMD_ENQUEUE, 0, 3, 0, 0, rrq_pkg::ST_OK);
    add_typed(rrq_pkg::CMD_DEQUEUE, 0, 0, 9, 1023, rrq_pkg::ST_OK);
    add_cmd(rrq_pkg::CMD_DEQUEUE, 0, 0, 0);
    // round-robin over three workers
    add_cfg(rrq_pkg::CFG_BIND_MODE, 1);
    add_cfg(rrq_pkg::CFG_WORKER_COUNT, 3);
    add_typed(rrq_pkg::CMD_ENQUEUE, 10, 16, 0, 0, rrq_pkg::ST_OK);
    add_typed(rrq_pkg::CMD_DEQUEUE, 0, 0, 1, 11, rrq_pkg::ST_OK);
    add_cmd(rrq_pkg::CMD_DEQUEUE, 0, 0, 1);
    add_typed(rrq_pkg::CMD_DEQUEUE, 0, 0, 1, 0, rrq_pkg::ST_EMPTY);
    // worker beyond the count still owns a queue
    add_typed(rrq_pkg::CMD_DEQUEUE, 0, 0, 5, 0, rrq_pkg::ST_EMPTY);
    add_cmd(rrq_pkg::CMD_DEQUEUE, 0, 0, 0);
    // zero workers behaves as one
    add_cfg(rrq_pkg::CFG_WORKER_COUNT, 0);
    add_cmd(rrq_pkg::CMD_ENQUEUE, 20, 22, 0);
    // count above the maximum clamps, full pool dealt out
    add_cfg(rrq_pkg::CFG_WORKER_COUNT, 31);
    add_cmd(rrq_pkg::CMD_ENQUEUE, 0, 1023, 0);
    add_cmd(rrq_pkg::CMD_DEQUEUE, 0, 0, 15);
    // replace mode
    add_cfg(rrq_pkg::CFG_ONE_LEVEL, 1);
    add_cfg(rrq_pkg::CFG_WORKER_COUNT, 16);
    add_cmd(rrq_pkg::CMD_ENQUEUE, 100, 117, 0);
    add_cmd(rrq_pkg::CMD_DEQUEUE, 0, 0, 0);
    add_cmd(rrq_pkg::CMD_DEQUEUE, 0, 0, 0);
    add_cmd(rrq_pkg::CMD_DEQUEUE, 0, 0, 15);
    // replace flag has no effect outside bind mode
    add_cfg(rrq_pkg::CFG_BIND_MODE, 0);
    add_cmd(rrq_pkg::CMD_ENQUEUE, 1000, 1023, 0);
    add_cmd(rrq_pkg::CMD_DEQUEUE, 0, 0, 3);
    add_cmd(rrq_pkg::CMD_DEQUEUE, 0, 0, 12);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_reg(directed_rows[i].reg_idx, int'(directed_rows[i].reg_val));
      else
        send_command(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin write_reg(rrq_pkg::CFG_BIND_MODE, 0); write_reg(rrq_pkg::CFG_ONE_LEVEL, 0);
                 write_reg(rrq_pkg::CFG_WORKER_COUNT, 1); end
        1: begin write_reg(rrq_pkg::CFG_BIND_MODE, 1); write_reg(rrq_pkg::CFG_ONE_LEVEL, 0);
                 write_reg(rrq_pkg::CFG_WORKER_COUNT, 4); end
        2: begin write_reg(rrq_pkg::CFG_BIND_MODE, 1); write_reg(rrq_pkg::CFG_ONE_LEVEL, 0);
                 write_reg(rrq_pkg::CFG_WORKER_COUNT, 16); end
        3: begin write_reg(rrq_pkg::CFG_BIND_MODE, 1); write_reg(rrq_pkg::CFG_ONE_LEVEL, 1);
                 write_reg(rrq_pkg::CFG_WORKER_COUNT, 7); end
        4: begin write_reg(rrq_pkg::CFG_BIND_MODE, 0); write_reg(rrq_pkg::CFG_ONE_LEVEL, 1);
                 write_reg(rrq_pkg::CFG_WORKER_COUNT, 16); end
        5: begin write_reg(rrq_pkg::CFG_BIND_MODE, 1); write_reg(rrq_pkg::CFG_ONE_LEVEL, 0);
                 write_reg(rrq_pkg::CFG_WORKER_COUNT, int'($urandom_range(16, 1))); end
        6: begin write_reg(rrq_pkg::CFG_BIND_MODE, 1); write_reg(rrq_pkg::CFG_ONE_LEVEL, 1);
                 write_reg(rrq_pkg::CFG_WORKER_COUNT, 1); end
        default: begin write_reg(rrq_pkg::CFG_BIND_MODE, 1);
                 write_reg(rrq_pkg::CFG_ONE_LEVEL, 0);
                 write_reg(rrq_pkg::CFG_WORKER_COUNT, 2); end
      endcase
      mode = idle_mode_t'(p % 4);
      set_idle(mode);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long receiver hold-off while commands keep coming
        if (p == 4 && i == 30) hold_token++;
        // sender pause until the block has emptied
        if (p == 7 && i == 50) begin
          in_bus.valid <= 1'b0;
          while (expected_results.size() != 0) @(posedge clk);
        end
        c = pick_command();
        send_command(c, 1'b0, '0);
      end
    end

    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fault_count == 0 && expected_results.size() == 0)
      $display("round_robin_ready_queues verification clean");
    else
      $display("round_robin_ready_queues verification failed");
    $finish;
  end

endmodule
